FILE: hdl/wmean_pkg.sv
// Shared constants and types of the multichannel window mean block.
`timescale 1ns / 1ps

package wmean_pkg;

  localparam int CHANNELS_DEFAULT    = 6;
  localparam int MAX_WINDOW_DEFAULT  = 64;
  localparam int SAMPLE_BITS_DEFAULT = 16;

  localparam int CHANNEL_BITS = 3;
  localparam int WLEN_BITS    = 7;
  localparam int FILL_BITS    = 7;
  localparam int MEAN_BITS    = 16;

  localparam logic [WLEN_BITS-1:0] WLEN_RESET = WLEN_BITS'(8);

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

FILE: hdl/wmean_ram.sv
// Simple dual-port synchronous RAM with a registered read port.
`timescale 1ns / 1ps

module wmean_ram #(
  parameter int ADDR_BITS = 4,
  parameter int WIDTH     = 16
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [ADDR_BITS-1:0] waddr,
  input  logic [WIDTH-1:0]     wdata,
  input  logic [ADDR_BITS-1:0] raddr,
  output logic [WIDTH-1:0]     rdata
);

  localparam int DEPTH = 1 << ADDR_BITS;

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hdl/wmean_div.sv
// Restoring divider that produces one quotient bit per cycle.
`timescale 1ns / 1ps

module wmean_div #(
  parameter int DIVIDEND_BITS = 22,
  parameter int DIVISOR_BITS  = 7
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [DIVIDEND_BITS-1:0] dividend,
  input  logic [DIVISOR_BITS-1:0]  divisor,
  output wmean_pkg::div_stat_t     stat,
  output logic [DIVIDEND_BITS-1:0] quotient
);

  localparam int CNT_BITS = $clog2(DIVIDEND_BITS + 1);

  logic [CNT_BITS-1:0]      cnt;
  logic                     done;
  logic [DIVIDEND_BITS-1:0] quo;
  logic [DIVISOR_BITS-1:0]  rem;
  logic [DIVISOR_BITS-1:0]  dsr;

  logic [DIVISOR_BITS:0]    shifted;
  logic [DIVISOR_BITS:0]    diff;
  logic                     take;
  logic [DIVISOR_BITS-1:0]  rem_next;

  always_comb begin
    shifted  = {rem, quo[DIVIDEND_BITS-1]};
    diff     = shifted - {1'b0, dsr};
    take     = shifted >= {1'b0, dsr};
    rem_next = take ? diff[DIVISOR_BITS-1:0] : shifted[DIVISOR_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= CNT_BITS'(DIVIDEND_BITS);
      end else if (cnt != '0) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_BITS'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dsr <= divisor;
    end else if (cnt != '0) begin
      quo <= {quo[DIVIDEND_BITS-2:0], take};
      rem <= rem_next;
    end
  end

  assign stat.busy = (cnt != '0);
  assign stat.done = done;
  assign quotient  = quo;

endmodule

FILE: hdl/multichannel_window_mean.sv
// Top level of the multichannel window mean block.
`timescale 1ns / 1ps

// Per-channel moving average of unsigned fixed-point samples. Each transfer
// carries a channel number and a sample; the block returns the truncated mean
// of that channel's last window_length samples (fewer while the window is
// still filling) together with the current fill level. A channel number of
// CHANNELS or above leaves all state alone and returns mean 0 and fill level
// 0. Samples sit in one RAM addressed by channel and slot; the fill count,
// write slot and running sum of each channel sit in a second RAM, guarded by
// one valid bit per channel so that reset and a write of window_length clear
// every channel at once without a clearing pass. An item goes through two
// RAM reads in turn, then the serial divider by the fill count, one quotient
// bit per cycle. The next item is taken as soon as the result is in the
// output register, even while that result still waits.
// Write window_length only while the block is idle.

module multichannel_window_mean #(
  parameter int CHANNELS    = wmean_pkg::CHANNELS_DEFAULT,
  parameter int MAX_WINDOW  = wmean_pkg::MAX_WINDOW_DEFAULT,
  parameter int SAMPLE_BITS = wmean_pkg::SAMPLE_BITS_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_wr_en,
  input  logic [wmean_pkg::WLEN_BITS-1:0]    cfg_wr_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [wmean_pkg::CHANNEL_BITS-1:0] channel,
  input  logic [SAMPLE_BITS-1:0]             sample,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [wmean_pkg::MEAN_BITS-1:0]    mean,
  output logic [wmean_pkg::FILL_BITS-1:0]    fill_level
);

  localparam int FB        = wmean_pkg::FILL_BITS;
  localparam int CH_BITS   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int SLOT_BITS = $clog2(MAX_WINDOW);
  localparam int SUM_BITS  = SAMPLE_BITS + SLOT_BITS;
  localparam int CW        = FB + SLOT_BITS + SUM_BITS;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD_CHAN,
    S_RD_SAMPLE,
    S_DIVIDE,
    S_DONE
  } state_t;

  state_t state;

  logic [wmean_pkg::WLEN_BITS-1:0] wlen;
  logic [FB-1:0]                   eff_len;
  logic [CHANNELS-1:0]             chan_vld;

  logic [CH_BITS-1:0]     ch_q;
  logic [SAMPLE_BITS-1:0] smp_q;
  logic [SLOT_BITS-1:0]   slot_q;
  logic [FB-1:0]          fill_q;
  logic [SUM_BITS-1:0]    sum_q;
  logic                   full_q;
  logic [FB-1:0]          fill_res;
  logic [wmean_pkg::MEAN_BITS-1:0] mean_res;

  logic [CW-1:0]          chan_rdata;
  logic [CW-1:0]          chan_wdata;
  logic                   chan_we;
  logic [SAMPLE_BITS-1:0] smp_rdata;
  logic [CH_BITS+SLOT_BITS-1:0] smp_raddr;

  logic [FB-1:0]          fill_rd;
  logic [SLOT_BITS-1:0]   slot_rd;
  logic [SUM_BITS-1:0]    sum_rd;
  logic [SLOT_BITS-1:0]   slot_eff;
  logic                   full;

  logic [SUM_BITS-1:0]    new_sum;
  logic [FB-1:0]          new_fill;
  logic [SLOT_BITS:0]     slot_inc;
  logic [SLOT_BITS-1:0]   new_slot;

  logic                   div_start;
  wmean_pkg::div_stat_t   div_stat;
  logic [SUM_BITS-1:0]    quotient;
  logic                   out_load;

  // Window length as the datapath sees it: zero means one, and it
  // saturates at the memory depth of a channel.
  always_comb begin
    eff_len = FB'(wlen);
    if (wlen == '0) begin
      eff_len = FB'(1);
    end else if (int'(wlen) > MAX_WINDOW) begin
      eff_len = FB'(MAX_WINDOW);
    end
  end

  // A channel whose valid bit is clear reads as freshly cleared.
  always_comb begin
    if (chan_vld[ch_q]) begin
      fill_rd = chan_rdata[CW-1 -: FB];
      slot_rd = chan_rdata[SUM_BITS +: SLOT_BITS];
      sum_rd  = chan_rdata[SUM_BITS-1:0];
    end else begin
      fill_rd = '0;
      slot_rd = '0;
      sum_rd  = '0;
    end
    slot_eff  = (slot_rd >= eff_len) ? '0 : slot_rd;
    full      = (fill_rd >= eff_len);
    smp_raddr = {ch_q, slot_eff};
  end

  always_comb begin
    new_sum  = sum_q - (full_q ? SUM_BITS'(smp_rdata) : '0) + SUM_BITS'(smp_q);
    new_fill = full_q ? eff_len : fill_q + 1'b1;
    slot_inc = (SLOT_BITS+1)'(slot_q) + 1'b1;
    new_slot = (slot_inc >= eff_len) ? '0 : slot_inc[SLOT_BITS-1:0];
    chan_wdata = {new_fill, new_slot, new_sum};
    chan_we    = (state == S_RD_SAMPLE);
    div_start  = (state == S_RD_SAMPLE);
    out_load   = (state == S_DONE) && (!out_valid || out_ready);
  end

  assign in_ready = (state == S_IDLE);

  wmean_ram #(
    .ADDR_BITS (CH_BITS),
    .WIDTH     (CW)
  ) u_chan_ram (
    .clk   (clk),
    .we    (chan_we),
    .waddr (ch_q),
    .wdata (chan_wdata),
    .raddr (CH_BITS'(channel)),
    .rdata (chan_rdata)
  );

  wmean_ram #(
    .ADDR_BITS (CH_BITS + SLOT_BITS),
    .WIDTH     (SAMPLE_BITS)
  ) u_sample_ram (
    .clk   (clk),
    .we    (chan_we),
    .waddr ({ch_q, slot_q}),
    .wdata (smp_q),
    .raddr (smp_raddr),
    .rdata (smp_rdata)
  );

  wmean_div #(
    .DIVIDEND_BITS (SUM_BITS),
    .DIVISOR_BITS  (FB)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (new_sum),
    .divisor  (new_fill),
    .stat     (div_stat),
    .quotient (quotient)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      wlen      <= wmean_pkg::WLEN_RESET;
      chan_vld  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        wlen     <= cfg_wr_data;
        chan_vld <= '0;
      end else if (chan_we) begin
        chan_vld[ch_q] <= 1'b1;
      end

      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            if (int'(channel) >= CHANNELS) begin
              state <= S_DONE;
            end else begin
              state <= S_RD_CHAN;
            end
          end
        end
        S_RD_CHAN: begin
          state <= S_RD_SAMPLE;
        end
        S_RD_SAMPLE: begin
          state <= S_DIVIDE;
        end
        S_DIVIDE: begin
          if (div_stat.done) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Datapath registers; the control flow above decides when they matter.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      ch_q     <= CH_BITS'(channel);
      smp_q    <= sample;
      mean_res <= '0;
      fill_res <= '0;
    end
    if (state == S_RD_CHAN) begin
      slot_q <= slot_eff;
      fill_q <= fill_rd;
      sum_q  <= sum_rd;
      full_q <= full;
    end
    if (state == S_RD_SAMPLE) begin
      fill_res <= new_fill;
    end
    if (state == S_DIVIDE && div_stat.done) begin
      mean_res <= wmean_pkg::MEAN_BITS'(quotient);
    end
    if (out_load) begin
      mean       <= mean_res;
      fill_level <= fill_res;
    end
  end

  a_div_start_free: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_stat.busy)
    else $error("divider started while busy");

  a_div_after_write: assert property (@(posedge clk) disable iff (rst)
    chan_we |=> (state == S_DIVIDE) && div_stat.busy)
    else $error("channel update not followed by a division");

  a_done_in_divide: assert property (@(posedge clk) disable iff (rst)
    div_stat.done |-> (state == S_DIVIDE))
    else $error("divider finished outside the divide phase");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    (out_valid && fill_level != '0) |-> (fill_level <= eff_len))
    else $error("fill level above window length");

  a_load_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !out_load)
    else $error("result loaded over a pending result");

endmodule

FILE: bench/testbench.sv
// Self-checking testbench for the multichannel window mean block.
`timescale 1ns / 1ps

module testbench;

  localparam int CHANNELS         = wmean_pkg::CHANNELS_DEFAULT;
  localparam int MAX_WINDOW       = wmean_pkg::MAX_WINDOW_DEFAULT;
  localparam int SAMPLE_BITS      = wmean_pkg::SAMPLE_BITS_DEFAULT;
  localparam int CHANNEL_BITS     = wmean_pkg::CHANNEL_BITS;
  localparam int WLEN_BITS        = wmean_pkg::WLEN_BITS;
  localparam int FILL_BITS        = wmean_pkg::FILL_BITS;
  localparam int MEAN_BITS        = wmean_pkg::MEAN_BITS;
  localparam logic [WLEN_BITS-1:0] WLEN_RESET = wmean_pkg::WLEN_RESET;
  localparam int SLOT_BITS        = $clog2(MAX_WINDOW);
  localparam int SUM_BITS         = SAMPLE_BITS + SLOT_BITS;
  localparam int TOP_CHANNEL      = (1 << CHANNEL_BITS) - 1;
  localparam int SETTLE_CYCLES    = 4;
  localparam int TAIL_CYCLES      = 60;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int HOLD_AT_FIRST    = 260;
  localparam int HOLD_AT_SECOND   = 760;
  localparam int PHASES           = 6;
  localparam int PHASE_ITEMS      = 170;
  localparam int CYCLE_LIMIT      = 400000;

  typedef enum logic [1:0] {
    ENTRY_SAMPLE,
    ENTRY_SET_LENGTH,
    ENTRY_DRAIN
  } entry_kind_t;

  typedef struct packed {
    entry_kind_t                 kind;
    logic [CHANNEL_BITS-1:0]     channel;
    logic [SAMPLE_BITS-1:0]      sample;
    logic [WLEN_BITS-1:0]        length;
    logic [2:0]                  gap;
  } pending_entry_t;

  typedef struct packed {
    logic [MEAN_BITS-1:0] mean;
    logic [FILL_BITS-1:0] fill;
  } mean_result_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    cfg_wr_en = 1'b0;
  logic [WLEN_BITS-1:0]    cfg_wr_data = '0;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic [CHANNEL_BITS-1:0] channel = '0;
  logic [SAMPLE_BITS-1:0]  sample = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic [MEAN_BITS-1:0]    mean;
  logic [FILL_BITS-1:0]    fill_level;

  pending_entry_t pending[$];
  mean_result_t   expected_means[$];

  int unsigned sent_count = 0;
  int unsigned results_seen = 0;
  int unsigned cycle_count = 0;
  int          error_count = 0;
  int          gap_left = 0;
  int          quiet_cycles = 0;
  int          stall_left = 0;
  logic        stimulus_done = 1'b0;
  logic        sender_calm = 1'b0;
  logic        receiver_calm = 1'b0;

  // Shadow copy of the per-channel windows.
  logic [WLEN_BITS-1:0]   length_setting;
  logic [SAMPLE_BITS-1:0] window_store [CHANNELS*MAX_WINDOW];
  logic [FILL_BITS-1:0]   fill_of [CHANNELS];
  logic [SLOT_BITS-1:0]   slot_of [CHANNELS];
  logic [SUM_BITS-1:0]    sum_of [CHANNELS];

  multichannel_window_mean dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .channel    (channel),
    .sample     (sample),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .mean       (mean),
    .fill_level (fill_level)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic int active_length();
    if (length_setting == '0) return 1;
    if (length_setting > MAX_WINDOW) return MAX_WINDOW;
    return int'(length_setting);
  endfunction

  task automatic clear_windows();
    for (int c = 0; c < CHANNELS; c++) begin
      fill_of[c] = '0;
      slot_of[c] = '0;
      sum_of[c]  = '0;
    end
  endtask

  function automatic mean_result_t predict_mean(
    input logic [CHANNEL_BITS-1:0] ch,
    input logic [SAMPLE_BITS-1:0]  smp
  );
    mean_result_t r;
    int len;
    int slot;
    int idx;
    r = '0;
    if (ch >= CHANNELS) return r;
    len  = active_length();
    slot = int'(slot_of[ch]);
    if (slot >= len) slot = 0;
    idx = ch * MAX_WINDOW + slot;
    // A full window loses its oldest sample, which sits in the slot being overwritten.
    if (fill_of[ch] >= len) begin
      sum_of[ch]  = sum_of[ch] - SUM_BITS'(window_store[idx]);
      fill_of[ch] = FILL_BITS'(len);
    end else begin
      fill_of[ch] = fill_of[ch] + 1'b1;
    end
    window_store[idx] = smp;
    sum_of[ch] = sum_of[ch] + SUM_BITS'(smp);
    slot++;
    if (slot >= len) slot = 0;
    slot_of[ch] = SLOT_BITS'(slot);
    r.mean = MEAN_BITS'(sum_of[ch] / fill_of[ch]);
    r.fill = fill_of[ch];
    return r;
  endfunction

  task automatic add_pending(input pending_entry_t e);
    pending = {pending, e};
  endtask

  task automatic queue_sample(input logic [CHANNEL_BITS-1:0] ch,
                              input logic [SAMPLE_BITS-1:0] smp);
    pending_entry_t e;
    e = '0;
    e.kind    = ENTRY_SAMPLE;
    e.channel = ch;
    e.sample  = smp;
    e.gap     = sender_calm ? 3'd0 : 3'($urandom_range(0, 6));
    add_pending(e);
  endtask

  task automatic queue_length(input logic [WLEN_BITS-1:0] len);
    pending_entry_t e;
    e = '0;
    e.kind   = ENTRY_SET_LENGTH;
    e.length = len;
    add_pending(e);
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  always @(posedge clk) begin : drive_samples
    logic                    nxt_valid;
    logic                    nxt_wr;
    logic [CHANNEL_BITS-1:0] nxt_ch;
    logic [SAMPLE_BITS-1:0]  nxt_smp;
    logic [WLEN_BITS-1:0]    nxt_len;
    pending_entry_t          head;
    nxt_valid = in_valid;
    nxt_wr    = 1'b0;
    nxt_ch    = channel;
    nxt_smp   = sample;
    nxt_len   = cfg_wr_data;
    if (rst) begin
      nxt_valid      = 1'b0;
      gap_left       = 0;
      quiet_cycles   = 0;
      length_setting = WLEN_RESET;
      clear_windows();
    end else begin
      if (in_valid && in_ready) begin
        expected_means = {expected_means, predict_mean(channel, sample)};
        sent_count <= sent_count + 1;
        nxt_valid = 1'b0;
        gap_left = (pending.size() > 0) ? int'(pending[0].gap) : 0;
      end
      if (!in_valid && sent_count == results_seen) begin
        quiet_cycles++;
      end else begin
        quiet_cycles = 0;
      end
      if (gap_left > 0) begin
        gap_left--;
      end else if (!nxt_valid && pending.size() > 0) begin
        head = pending[0];
        case (head.kind)
          ENTRY_SAMPLE: begin
            nxt_valid = 1'b1;
            nxt_ch    = head.channel;
            nxt_smp   = head.sample;
            void'(pending.pop_front());
          end
          ENTRY_SET_LENGTH: begin
            // Only written once every outstanding result has been collected.
            if (quiet_cycles >= SETTLE_CYCLES) begin
              nxt_wr  = 1'b1;
              nxt_len = head.length;
              length_setting = head.length;
              clear_windows();
              void'(pending.pop_front());
            end
          end
          default: begin
            if (quiet_cycles >= SETTLE_CYCLES) void'(pending.pop_front());
          end
        endcase
      end
    end
    in_valid      <= nxt_valid;
    channel       <= nxt_ch;
    sample        <= nxt_smp;
    cfg_wr_en     <= nxt_wr;
    cfg_wr_data   <= nxt_len;
    stimulus_done <= !rst && pending.size() == 0 && !nxt_valid;
  end

  always @(posedge clk) begin : collect_means
    logic         nxt_ready;
    mean_result_t want;
    nxt_ready = out_ready;
    if (rst) begin
      nxt_ready  = 1'b0;
      stall_left = 0;
    end else if (out_valid && out_ready) begin
      if (expected_means.size() == 0) begin
        $display("%0t: unexpected result, expected none, got mean %h fill %0d",
                 $time, mean, fill_level);
        error_count++;
      end else begin
        want = expected_means.pop_front();
        if (mean !== want.mean) begin
          $display("%0t: mean mismatch, expected %h, got %h", $time, want.mean, mean);
          error_count++;
        end
        if (fill_level !== want.fill) begin
          $display("%0t: fill level mismatch, expected %0d, got %0d",
                   $time, want.fill, fill_level);
          error_count++;
        end
      end
      results_seen <= results_seen + 1;
      if ((results_seen + 1) % 50 == 0) receiver_calm = ($urandom_range(0, 2) == 0);
      // Twice in the run the receiver holds off long enough to back up the input.
      if (results_seen + 1 == HOLD_AT_FIRST || results_seen + 1 == HOLD_AT_SECOND) begin
        stall_left = LONG_HOLD_CYCLES;
      end else if (receiver_calm) begin
        stall_left = 0;
      end else begin
        stall_left = $urandom_range(0, 6);
      end
      nxt_ready = (stall_left == 0);
    end else if (!out_ready) begin
      if (stall_left > 0) stall_left--;
      if (stall_left == 0) nxt_ready = 1'b1;
    end
    out_ready <= nxt_ready;
  end

  initial begin
    int                      ph;
    int                      n;
    int                      pick;
    int                      hot;
    logic [CHANNEL_BITS-1:0] ch;
    logic [SAMPLE_BITS-1:0]  smp;
    logic [WLEN_BITS-1:0]    len;
    pending_entry_t          pause_entry;

    // Reset window length: channels out of range, then extremes of the sample.
    queue_sample(CHANNEL_BITS'(CHANNELS), '1);
    queue_sample(CHANNEL_BITS'(TOP_CHANNEL), 16'h1234);
    queue_sample(3'd5, '0);
    queue_sample(3'd5, '1);
    queue_sample(3'd0, '1);
    // Window of one: every sample replaces the last.
    queue_length(7'd1);
    queue_sample(3'd1, 16'hAAAA);
    queue_sample(3'd1, 16'h5555);
    // A length of zero behaves as a length of one.
    queue_length(7'd0);
    queue_sample(3'd2, 16'h0001);
    queue_sample(3'd2, 16'hFFFE);
    queue_length(7'd2);
    queue_sample(3'd0, '1);
    queue_sample(3'd0, '1);
    queue_sample(3'd0, 16'h0001);
    queue_sample(3'd0, 16'h0002);
    // Rewriting the same length still clears the channel.
    queue_length(7'd3);
    queue_sample(3'd3, 16'd100);
    queue_sample(3'd3, 16'd200);
    queue_sample(3'd3, 16'd300);
    queue_sample(3'd3, 16'd400);
    queue_length(7'd3);
    queue_sample(3'd3, 16'd500);
    // Lengths above the maximum saturate.
    queue_length(7'd127);
    queue_sample(3'd4, '1);
    queue_sample(3'd4, '1);
    queue_sample(3'd4, '0);
    queue_sample(CHANNEL_BITS'(TOP_CHANNEL), '0);

    pause_entry = '0;
    pause_entry.kind = ENTRY_DRAIN;
    for (ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: len = 7'd64;
        1: len = 7'd2;
        2: len = 7'd127;
        3: len = WLEN_BITS'($urandom_range(1, MAX_WINDOW));
        4: len = 7'd1;
        default: len = WLEN_RESET;
      endcase
      queue_length(len);
      // One busy channel per phase so that long windows fill and wrap.
      hot = $urandom_range(0, CHANNELS - 1);
      for (n = 0; n < PHASE_ITEMS; n++) begin
        if (n % 40 == 0) sender_calm = ($urandom_range(0, 3) == 0);
        if (ph == 2 && n == PHASE_ITEMS / 2) add_pending(pause_entry);
        pick = $urandom_range(0, 99);
        if (pick < 5) begin
          ch = CHANNEL_BITS'($urandom_range(CHANNELS, TOP_CHANNEL));
        end else if (pick < 55) begin
          ch = CHANNEL_BITS'(hot);
        end else begin
          ch = CHANNEL_BITS'($urandom_range(0, CHANNELS - 1));
        end
        case ($urandom_range(0, 9))
          0: smp = '0;
          1: smp = '1;
          2: smp = SAMPLE_BITS'($urandom_range(0, 255));
          default: smp = SAMPLE_BITS'($urandom);
        endcase
        queue_sample(ch, smp);
      end
    end

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    @(posedge clk);
    while (!stimulus_done || sent_count != results_seen) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0 && expected_means.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

FILE: multichannel_window_mean.f
hdl/wmean_pkg.sv
hdl/wmean_ram.sv
hdl/wmean_div.sv
hdl/multichannel_window_mean.sv
bench/testbench.sv
